[rtl/jqc_pkg.sv]
// Shared types, constants and keyboard lookup functions for the layout converter.
package jqc_pkg;

   localparam logic [7:0] MAX_CHARS_RESET = 8'd99;

   localparam logic [7:0] CHAR_TILDE    = 8'h7E;
   localparam logic [7:0] CHAR_BACKTICK = 8'h60;

   localparam logic [7:0] LEAD_D0 = 8'hD0;
   localparam logic [7:0] LEAD_D1 = 8'hD1;

   // Key characters, first character in the top byte.
   localparam logic [255:0] LOWER_KEYS = "f,dult;pbqrkvyjghcnea[wxio]sm'.z";
   localparam logic [255:0] UPPER_KEYS = "F<DULT:PBQRKVYJGHCNEA{WXIO}SM\">Z";

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       out_valid;
      logic       out_last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] lead_byte;
      logic [2:0] seq_length;
      logic [2:0] bytes_seen;
      logic [7:0] out_count;
      logic       stopped;
   } state_type;

   function automatic logic [2:0] seq_len_of(input logic [7:0] c);
      logic [2:0] len;
      len = 3'd1;
      if (c[7] == 1'b0) begin
         len = 3'd1;
      end else if (c[7:5] == 3'b110) begin
         len = 3'd2;
      end else if (c[7:4] == 4'b1110) begin
         len = 3'd3;
      end else if (c[7:3] == 5'b11110) begin
         len = 3'd4;
      end
      return len;
   endfunction

   function automatic logic [7:0] key_lower(input logic [4:0] idx);
      return LOWER_KEYS[8'd255 - {idx, 3'b000} -: 8];
   endfunction

   function automatic logic [7:0] key_upper(input logic [4:0] idx);
      return UPPER_KEYS[8'd255 - {idx, 3'b000} -: 8];
   endfunction

   function automatic logic [7:0] map_pair(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] ch;
      logic [7:0] off;
      ch  = a;
      off = b - 8'h90;
      if (a == LEAD_D0) begin
         if (b inside {[8'h90:8'hAF]}) begin
            ch = key_upper(off[4:0]);
         end else if (b inside {[8'hB0:8'hBF]}) begin
            ch = key_lower({1'b0, b[3:0]});
         end else if (b == 8'h81) begin
            ch = CHAR_TILDE;
         end
      end else if (a == LEAD_D1) begin
         if (b inside {[8'h80:8'h8F]}) begin
            ch = key_lower({1'b1, b[3:0]});
         end else if (b == 8'h91) begin
            ch = CHAR_BACKTICK;
         end
      end
      return ch;
   endfunction

endpackage

[rtl/jqc_step.sv]
// Per-byte decode step: sequence gathering, letter lookup and character limit.
module jqc_step (
   input  jqc_pkg::state_type state_cur,
   input  jqc_pkg::req_type   item,
   input  logic [7:0]         max_chars,
   output jqc_pkg::state_type state_next,
   output jqc_pkg::rsp_type   rsp,
   output logic               has_rsp
);
   import jqc_pkg::*;

   logic [2:0] seen_inc;
   logic [2:0] len;
   logic       have;
   logic [7:0] ch;
   logic [7:0] count_inc;

   assign seen_inc = state_cur.bytes_seen + 3'd1;
   assign len      = seq_len_of(item.in_byte);

   always_comb begin
      state_next = state_cur;
      have       = 1'b0;
      ch         = 8'h00;
      if (state_cur.seq_length != 3'd0) begin
         state_next.bytes_seen = seen_inc;
         if (seen_inc >= state_cur.seq_length) begin
            ch = (state_cur.seq_length == 3'd2) ? map_pair(state_cur.lead_byte, item.in_byte)
                                                : state_cur.lead_byte;
            have                  = 1'b1;
            state_next.seq_length = 3'd0;
            state_next.bytes_seen = 3'd0;
         end else if (item.in_last) begin
            ch                    = state_cur.lead_byte;
            have                  = 1'b1;
            state_next.seq_length = 3'd0;
            state_next.bytes_seen = 3'd0;
         end
      end else if (!state_cur.stopped && state_cur.out_count < max_chars) begin
         if (len == 3'd1 || item.in_last) begin
            ch   = item.in_byte;
            have = 1'b1;
         end else begin
            state_next.lead_byte  = item.in_byte;
            state_next.seq_length = len;
            state_next.bytes_seen = 3'd1;
         end
      end

      count_inc = (state_cur.out_count == 8'hFF) ? state_cur.out_count
                                                 : state_cur.out_count + 8'd1;
      if (have) begin
         state_next.out_count = count_inc;
         if (count_inc >= max_chars) begin
            state_next.stopped = 1'b1;
         end
      end

      if (item.in_last) begin
         state_next = '0;
      end

      rsp.out_char  = have ? ch : 8'h00;
      rsp.out_valid = have;
      rsp.out_last  = item.in_last;
      has_rsp       = have | item.in_last;
   end

endmodule

[rtl/cyrillic_layout_to_qwerty_stream_unit.sv]
// Top level: Russian-layout UTF-8 byte stream to QWERTY key characters.
//
// Bytes of a UTF-8 string enter on req_ (valid/ready), in_last marking the
// final byte. Each two-byte Russian letter becomes the QWERTY character on
// the same key; ASCII passes through; other multi-byte sequences give their
// lead byte. At most max_chars characters per string (csr_ write, reset 99).
// Results leave on rsp_ (valid/ready): one per completed character and
// always one on the last byte of a string.
// An accepted byte is held in the input register, where the decode step and
// letter lookup run, and its item passes through the result register onto rsp_.
// One byte per cycle is sustained while rsp_ is not stalled.
// When rsp_ stalls, bytes that give no item still drain; a byte that gives
// an item waits in the input register, and req_ready drops once both the
// input and result registers are full.
// Synchronous reset clears the string state and the valid flags of both
// registers and sets max_chars to 99; no clearing pass is needed.
module cyrillic_layout_to_qwerty_stream_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  jqc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output jqc_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data
);
   import jqc_pkg::*;

   req_type    req_ff;
   logic       req_valid_ff, req_valid_in;
   state_type  state_ff, state_in;
   rsp_type    rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] max_chars_ff, max_chars_in;

   state_type  step_state;
   rsp_type    step_rsp;
   logic       step_has_rsp;
   logic       out_free;
   logic       fire;

   jqc_step u_step (
      .state_cur  (state_ff),
      .item       (req_ff),
      .max_chars  (max_chars_ff),
      .state_next (step_state),
      .rsp        (step_rsp),
      .has_rsp    (step_has_rsp)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid_ff && (!step_has_rsp || out_free);
   assign req_ready = !req_valid_ff || fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_ready) begin
         req_valid_in = req_valid;
      end
      state_in     = fire ? step_state : state_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (fire && step_has_rsp) begin
         rsp_in       = step_rsp;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      max_chars_in = csr_wr_en ? csr_wr_data : max_chars_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         max_chars_ff <= MAX_CHARS_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         max_chars_ff <= max_chars_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   a_last_clears : assert property (@(posedge clock) disable iff (reset)
      (fire && req_ff.in_last) |=> (state_ff.seq_length == 3'd0 && state_ff.out_count == 8'd0))
      else $error("string state not cleared after last byte");

   a_seen_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff.seq_length != 3'd0) |->
         (state_ff.bytes_seen != 3'd0 && state_ff.bytes_seen < state_ff.seq_length))
      else $error("pending sequence byte count out of range");

   a_empty_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.out_valid) |-> rsp_ff.out_last)
      else $error("item without a character that does not close the string");

   a_no_drop : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("pending item overwritten while stalled");

endmodule
